FILE: rtl/core/pairwise_gravity_velocity_update_defines.svh
// ----------------------------------------------------------------------------
// Pairwise gravity velocity update - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_GRAVITY_VELOCITY_UPDATE_DEFINES_SVH
`define PAIRWISE_GRAVITY_VELOCITY_UPDATE_DEFINES_SVH

// same-cycle implication
`define PGV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PGV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pgv_pkg.sv
// ----------------------------------------------------------------------------
// pgv_pkg
// Fixed field widths of the pairwise gravity velocity update.
// ----------------------------------------------------------------------------
`default_nettype none

package pgv_pkg;

  localparam int GAIN_W = 32;
  localparam int MASS_W = 40;
  localparam int VEL_FRAC_BITS = 16;

endpackage

`default_nettype wire

FILE: rtl/core/pgv_dly.sv
// ----------------------------------------------------------------------------
// pgv_dly
// Enabled shift line of N stages, used to keep side data aligned.
// ----------------------------------------------------------------------------
`default_nettype none

module pgv_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [0:N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) sr_r[i] <= '0;
    end else if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[N-1];

endmodule

`default_nettype wire

FILE: rtl/core/pgv_mul.sv
// ----------------------------------------------------------------------------
// pgv_mul
// Two-stage unsigned multiplier: two half-width partial products, then sum.
// ----------------------------------------------------------------------------
`default_nettype none

module pgv_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int BL = BW / 2;
  localparam int BH = BW - BL;

  logic [AW+BL-1:0] lo_r;
  logic [AW+BH-1:0] hi_r;
  logic [AW+BW-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r <= (AW+BL)'(a) * (AW+BL)'(b[BL-1:0]);
      hi_r <= (AW+BH)'(a) * (AW+BH)'(b[BW-1:BL]);
      p_r  <= ((AW+BW)'(hi_r) << BL) + (AW+BW)'(lo_r);
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

FILE: rtl/core/pgv_isqrt.sv
// ----------------------------------------------------------------------------
// pgv_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pgv_isqrt #(
  parameter int XW = 65,
  parameter int SW = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] x,
  output logic [SW-1:0] s
);

  localparam int TW = 2 * SW + 1;

  logic [TW-1:0] rem_r [1:SW-1];
  logic [SW-1:0] res_r [1:SW];

  for (genvar k = 1; k <= SW; k++) begin : g_bit
    localparam int B = SW - k;
    logic [TW-1:0] rem_in;
    logic [TW-1:0] trial;
    logic [SW-1:0] res_in;
    logic          fit;

    if (k == 1) begin : g_first
      assign rem_in = TW'(x);
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
    end

    // (res + 2^B)^2 - res^2
    assign trial = (TW'(res_in) << (B + 1)) + (TW'(1) << (2 * B));
    assign fit   = (rem_in >= trial);

    if (k < SW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= fit ? (rem_in - trial) : rem_in;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        res_r[k] <= res_in | (fit ? (SW'(1) << B) : '0);
      end
    end
  end

  assign s = res_r[SW];

endmodule

`default_nettype wire

FILE: rtl/core/pgv_div.sv
// ----------------------------------------------------------------------------
// pgv_div
// Pipelined restoring divider, one quotient bit per stage; quotients at or
// above 2^QW clamp to all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module pgv_div #(
  parameter int NW = 148,
  parameter int DW = 98,
  parameter int QW = 48
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int RW = DW + QW;
  localparam int CW = ((NW > RW) ? NW : RW) + 1;

  logic [RW-1:0] rem_r [0:QW-1];
  logic [DW-1:0] d_r   [0:QW-1];
  logic [QW-1:0] q_r   [0:QW];
  logic          ovf_r [0:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= (CW'(num) >= (CW'(den) << QW));
      rem_r[0] <= RW'(num);
      d_r[0]   <= den;
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_bit
    localparam int B = QW - k;
    logic [RW-1:0] dsh;
    logic          ge;
    logic [QW-1:0] q_nxt;

    assign dsh = RW'(d_r[k-1]) << B;
    assign ge  = (rem_r[k-1] >= dsh);

    always_comb begin
      q_nxt    = q_r[k-1];
      q_nxt[B] = ge;
    end

    if (k < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? (rem_r[k-1] - dsh) : rem_r[k-1];
          d_r[k]   <= d_r[k-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]   <= q_nxt;
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign quo = ovf_r[QW] ? '1 : q_r[QW];

endmodule

`default_nettype wire

FILE: rtl/core/pairwise_gravity_velocity_update.sv
// Takes one body pair per clock while in_tready is high and returns one velocity
// word per pair: the square root of r^2 spends one stage per root bit and each
// of the four dividers one stage per quotient bit. A two-word output buffer
// lets the pipeline keep taking pairs while a result waits; in_tready drops
// only once that buffer is full. gain is written through cfg_we/cfg_wdata while
// idle; the user must keep to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
// pairwise_gravity_velocity_update
// 2D pairwise gravity step: v1 += gain*m2*d/r^3, v2 -= gain*m1*d/r^3.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pairwise_gravity_velocity_update_defines.svh"

module pairwise_gravity_velocity_update #(
  parameter int POSITION_BITS = 32,
  parameter int VELOCITY_BITS = 48,
  localparam int IN_RAW = 4 * POSITION_BITS + 2 * pgv_pkg::MASS_W + 4 * VELOCITY_BITS,
  localparam int IN_W   = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_W  = ((4 * VELOCITY_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [pgv_pkg::GAIN_W-1:0] cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // first_x, first_y, first_mass, first_vx, first_vy,
  // second_x, second_y, second_mass, second_vx, second_vy
  input  logic [IN_W-1:0]           in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // new_first_vx, new_first_vy, new_second_vx, new_second_vy
  output logic [OUT_W-1:0]          out_tdata,
  // coincident
  output logic                      out_tuser
);

  localparam int PB   = POSITION_BITS;
  localparam int VB   = VELOCITY_BITS;
  localparam int MW   = pgv_pkg::MASS_W;
  localparam int GW   = pgv_pkg::GAIN_W;
  localparam int SW   = PB + 1;
  localparam int R2W  = 2 * PB + 1;
  localparam int R3W  = R2W + SW;
  localparam int GMW  = GW + MW;
  localparam int PW   = GMW + PB;
  localparam int SH   = 2 * (PB - 2) - pgv_pkg::VEL_FRAC_BITS;
  localparam int NW   = PW + SH;
  localparam int SBW  = 3 + 4 * VB;
  localparam int DLY_MASS = 1 + SW;
  localparam int DLY_MAG  = 3 + SW;
  localparam int DLY_SB   = 6 + SW + VB;

  localparam int O_FX  = 0;
  localparam int O_FY  = O_FX + PB;
  localparam int O_FM  = O_FY + PB;
  localparam int O_FVX = O_FM + MW;
  localparam int O_FVY = O_FVX + VB;
  localparam int O_SX  = O_FVY + VB;
  localparam int O_SY  = O_SX + PB;
  localparam int O_SM  = O_SY + PB;
  localparam int O_SVX = O_SM + MW;
  localparam int O_SVY = O_SVX + VB;

  localparam logic [VB-1:0] VEL_SIGN = {1'b1, {(VB-1){1'b0}}};

  function automatic logic [VB-1:0] vel_move(input logic [VB-1:0] v,
                                             input logic [VB-1:0] q,
                                             input logic          up);
    logic [VB-1:0] u;
    logic [VB:0]   s;
    logic [VB-1:0] r;
    u = v ^ VEL_SIGN;
    if (up) begin
      s = {1'b0, u} + {1'b0, q};
      r = s[VB] ? '1 : s[VB-1:0];
    end else begin
      s = {1'b0, u} - {1'b0, q};
      r = s[VB] ? '0 : s[VB-1:0];
    end
    return r ^ VEL_SIGN;
  endfunction

  logic          en;
  logic [GW-1:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
    end else if (cfg_we) begin
      gain_r <= cfg_wdata;
    end
  end

  // stage 1: offsets, magnitudes, signs
  logic [PB:0]   dx_nxt, dy_nxt, mx_nxt, my_nxt;
  logic          s1_v_r, s1_coin_r, s1_nx_r, s1_ny_r;
  logic [PB-1:0] s1_ax_r, s1_ay_r;
  logic [MW-1:0] s1_m1_r, s1_m2_r;
  logic [VB-1:0] s1_v1x_r, s1_v1y_r, s1_v2x_r, s1_v2y_r;

  assign dx_nxt = {in_tdata[O_SX+PB-1], in_tdata[O_SX +: PB]}
                - {in_tdata[O_FX+PB-1], in_tdata[O_FX +: PB]};
  assign dy_nxt = {in_tdata[O_SY+PB-1], in_tdata[O_SY +: PB]}
                - {in_tdata[O_FY+PB-1], in_tdata[O_FY +: PB]};
  assign mx_nxt = dx_nxt[PB] ? (~dx_nxt + 1'b1) : dx_nxt;
  assign my_nxt = dy_nxt[PB] ? (~dy_nxt + 1'b1) : dy_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_coin_r <= (dx_nxt == '0) && (dy_nxt == '0);
      s1_nx_r   <= dx_nxt[PB];
      s1_ny_r   <= dy_nxt[PB];
      s1_ax_r   <= mx_nxt[PB-1:0];
      s1_ay_r   <= my_nxt[PB-1:0];
      s1_m1_r   <= in_tdata[O_FM +: MW];
      s1_m2_r   <= in_tdata[O_SM +: MW];
      s1_v1x_r  <= in_tdata[O_FVX +: VB];
      s1_v1y_r  <= in_tdata[O_FVY +: VB];
      s1_v2x_r  <= in_tdata[O_SVX +: VB];
      s1_v2y_r  <= in_tdata[O_SVY +: VB];
    end
  end

  // r^2, sqrt, r^3
  logic [2*PB-1:0] ax2, ay2;
  logic [R2W-1:0]  r2_r, r2_d;
  logic [SW-1:0]   root;
  logic [R3W-1:0]  r3;

  pgv_mul #(.AW(PB), .BW(PB)) u_mul_ax2 (
    .clk(clk), .en(en), .a(s1_ax_r), .b(s1_ax_r), .p(ax2)
  );
  pgv_mul #(.AW(PB), .BW(PB)) u_mul_ay2 (
    .clk(clk), .en(en), .a(s1_ay_r), .b(s1_ay_r), .p(ay2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r <= {1'b0, ax2} + {1'b0, ay2};
    end
  end

  pgv_isqrt #(.XW(R2W), .SW(SW)) u_isqrt (
    .clk(clk), .en(en), .x(r2_r), .s(root)
  );
  pgv_dly #(.W(R2W), .N(SW)) u_dly_r2 (
    .clk(clk), .rst_n(rst_n), .en(en), .d(r2_r), .q(r2_d)
  );
  pgv_mul #(.AW(R2W), .BW(SW)) u_mul_r3 (
    .clk(clk), .en(en), .a(r2_d), .b(root), .p(r3)
  );

  // numerators gain*m*|d|
  logic [MW-1:0]  m1_d, m2_d;
  logic [PB-1:0]  ax_d, ay_d;
  logic [GMW-1:0] gm1, gm2;
  logic [PW-1:0]  p1x, p1y, p2x, p2y;

  pgv_dly #(.W(2*MW), .N(DLY_MASS)) u_dly_mass (
    .clk(clk), .rst_n(rst_n), .en(en),
    .d({s1_m1_r, s1_m2_r}), .q({m1_d, m2_d})
  );
  pgv_dly #(.W(2*PB), .N(DLY_MAG)) u_dly_mag (
    .clk(clk), .rst_n(rst_n), .en(en),
    .d({s1_ax_r, s1_ay_r}), .q({ax_d, ay_d})
  );

  pgv_mul #(.AW(GW), .BW(MW)) u_mul_gm1 (
    .clk(clk), .en(en), .a(gain_r), .b(m1_d), .p(gm1)
  );
  pgv_mul #(.AW(GW), .BW(MW)) u_mul_gm2 (
    .clk(clk), .en(en), .a(gain_r), .b(m2_d), .p(gm2)
  );
  pgv_mul #(.AW(GMW), .BW(PB)) u_mul_p2x (
    .clk(clk), .en(en), .a(gm2), .b(ax_d), .p(p2x)
  );
  pgv_mul #(.AW(GMW), .BW(PB)) u_mul_p2y (
    .clk(clk), .en(en), .a(gm2), .b(ay_d), .p(p2y)
  );
  pgv_mul #(.AW(GMW), .BW(PB)) u_mul_p1x (
    .clk(clk), .en(en), .a(gm1), .b(ax_d), .p(p1x)
  );
  pgv_mul #(.AW(GMW), .BW(PB)) u_mul_p1y (
    .clk(clk), .en(en), .a(gm1), .b(ay_d), .p(p1y)
  );

  // quotients
  logic [VB-1:0] q1x, q1y, q2x, q2y;

  pgv_div #(.NW(NW), .DW(R3W), .QW(VB)) u_div_1x (
    .clk(clk), .en(en), .num(NW'(p2x) << SH), .den(r3), .quo(q1x)
  );
  pgv_div #(.NW(NW), .DW(R3W), .QW(VB)) u_div_1y (
    .clk(clk), .en(en), .num(NW'(p2y) << SH), .den(r3), .quo(q1y)
  );
  pgv_div #(.NW(NW), .DW(R3W), .QW(VB)) u_div_2x (
    .clk(clk), .en(en), .num(NW'(p1x) << SH), .den(r3), .quo(q2x)
  );
  pgv_div #(.NW(NW), .DW(R3W), .QW(VB)) u_div_2y (
    .clk(clk), .en(en), .num(NW'(p1y) << SH), .den(r3), .quo(q2y)
  );

  // side data
  logic          sb_v;
  logic          sb_coin, sb_nx, sb_ny;
  logic [VB-1:0] sb_v1x, sb_v1y, sb_v2x, sb_v2y;

  pgv_dly #(.W(1), .N(DLY_SB)) u_dly_valid (
    .clk(clk), .rst_n(rst_n), .en(en), .d(s1_v_r), .q(sb_v)
  );
  pgv_dly #(.W(SBW), .N(DLY_SB)) u_dly_side (
    .clk(clk), .rst_n(rst_n), .en(en),
    .d({s1_coin_r, s1_nx_r, s1_ny_r, s1_v1x_r, s1_v1y_r, s1_v2x_r, s1_v2y_r}),
    .q({sb_coin, sb_nx, sb_ny, sb_v1x, sb_v1y, sb_v2x, sb_v2y})
  );

  // final stage: saturating update
  logic            fin_v_r, fin_c_r;
  logic [4*VB-1:0] fin_d_r, fin_nxt;

  always_comb begin
    if (sb_coin) begin
      fin_nxt = {sb_v2y, sb_v2x, sb_v1y, sb_v1x};
    end else begin
      fin_nxt = {vel_move(sb_v2y, q2y, sb_ny),
                 vel_move(sb_v2x, q2x, sb_nx),
                 vel_move(sb_v1y, q1y, !sb_ny),
                 vel_move(sb_v1x, q1x, !sb_nx)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= sb_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_d_r <= fin_nxt;
      fin_c_r <= sb_coin;
    end
  end

  // output register plus skid word
  logic            out_v_r, out_c_r, sk_v_r, sk_c_r, take;
  logic [4*VB-1:0] out_d_r, sk_d_r;

  assign en   = !sk_v_r;
  assign take = en && fin_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (sk_v_r) begin
        out_v_r <= 1'b1;
        sk_v_r  <= 1'b0;
      end else begin
        out_v_r <= take;
      end
    end else if (take) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      if (sk_v_r) begin
        out_d_r <= sk_d_r;
        out_c_r <= sk_c_r;
      end else begin
        out_d_r <= fin_d_r;
        out_c_r <= fin_c_r;
      end
    end else if (take) begin
      sk_d_r <= fin_d_r;
      sk_c_r <= fin_c_r;
    end
  end

  assign in_tready  = en;
  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_W'(out_d_r);
  assign out_tuser  = out_c_r;

  `PGV_ASSERT_SAME(a_skid_behind_out, sk_v_r, out_v_r, "skid word held with empty output")
  `PGV_ASSERT_SAME(a_skid_fill, $rose(sk_v_r), $past(out_v_r && !out_tready), "skid filled without stall")
  `PGV_ASSERT_NEXT(a_pipe_freeze, sk_v_r, $stable(fin_v_r) && $stable(fin_d_r), "pipeline moved while frozen")

endmodule

`default_nettype wire
